@@ rtl/sbld_pkg.sv @@
package sbld_pkg;

  localparam int KMER_LEN      = 17;
  localparam int MINIMIZER_LEN = 5;
  localparam int POSITION_BITS = 16;

  localparam int WIN_W      = 2 * KMER_LEN;
  localparam int MMER_W     = 2 * MINIMIZER_LEN;
  localparam int NCAND      = KMER_LEN - MINIMIZER_LEN + 1;
  localparam int OFF_W      = (NCAND > 1) ? $clog2(NCAND) : 1;
  localparam int GRP_SIZE   = 4;
  localparam int NGRP       = (NCAND + GRP_SIZE - 1) / GRP_SIZE;

  localparam int SMER_BASES = 32;
  localparam int SMER_W     = 64;
  localparam int LEN_W      = 6;
  localparam int OWNER_W    = 16;
  localparam int HASH_W     = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [HASH_W-1:0] HASH_C1 = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] HASH_C2 = 32'hc2b2ae35;

  typedef logic [1:0] base_t;

  typedef enum logic {
    KIND_OPEN,
    KIND_STEP
  } kind_e;

  // one queued work item: the window as it stands after this base
  typedef struct packed {
    kind_e                    kind;
    logic [WIN_W-1:0]         window;
    base_t                    base;
    logic [POSITION_BITS-1:0] pos_base;
    logic                     read_end;
  } work_t;

  localparam base_t BASE_A = 2'd0;
  localparam base_t BASE_C = 2'd1;
  localparam base_t BASE_G = 2'd2;
  localparam base_t BASE_T = 2'd3;

  function automatic logic [7:0] ascii_of(input base_t b);
    logic [7:0] a;
    case (b)
      BASE_A:  a = 8'h41;
      BASE_C:  a = 8'h43;
      BASE_G:  a = 8'h47;
      BASE_T:  a = 8'h54;
      default: a = 8'h41;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/sbld_intf.sv @@
interface sbld_base_if
  import sbld_pkg::*;
();
  logic  valid;
  logic  ready;
  base_t base_code;
  logic  read_end;

  modport source (output valid, output base_code, output read_end, input ready);
  modport sink   (input valid, input base_code, input read_end, output ready);
endinterface

interface sbld_smer_if
  import sbld_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SMER_W-1:0]  packed_bases;
  logic [LEN_W-1:0]   supermer_len;
  logic [OWNER_W-1:0] owner_id;
  logic               read_done;
  logic               last_in_run;

  modport source (output valid, output packed_bases, output supermer_len, output owner_id,
                  output read_done, output last_in_run, input ready);
  modport sink   (input valid, input packed_bases, input supermer_len, input owner_id,
                  input read_done, input last_in_run, output ready);
endinterface

@@ rtl/sbld_front.sv @@
module sbld_front
  import sbld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sbld_base_if.sink  in_i,
  output logic       push_o,
  output work_t      push_data_o,
  input  logic       full_i
);

  logic [WIN_W-1:0]         win_q;
  logic [POSITION_BITS-1:0] rdpos_q;
  logic                     full_q;

  logic                     accept;
  logic [WIN_W-1:0]         win_d;
  logic [POSITION_BITS-1:0] n;
  logic                     first_kmer;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign win_d      = {win_q[WIN_W-3:0], in_i.base_code};
  assign n          = rdpos_q + POSITION_BITS'(1);
  assign first_kmer = !full_q && (rdpos_q == POSITION_BITS'(KMER_LEN - 1));

  // a k-mer completing on the read's last base opens nothing that is ever sent
  assign push_o = accept && (full_q || (first_kmer && !in_i.read_end));

  always_comb begin
    push_data_o.kind     = full_q ? KIND_STEP : KIND_OPEN;
    push_data_o.window   = win_d;
    push_data_o.base     = in_i.base_code;
    push_data_o.pos_base = rdpos_q - POSITION_BITS'(KMER_LEN - 1);
    push_data_o.read_end = in_i.read_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      rdpos_q <= '0;
      full_q  <= 1'b0;
    end else if (accept) begin
      if (in_i.read_end) begin
        win_q   <= '0;
        rdpos_q <= '0;
        full_q  <= 1'b0;
      end else begin
        win_q   <= win_d;
        rdpos_q <= n;
        full_q  <= full_q || first_kmer;
      end
    end
  end

endmodule

@@ rtl/sbld_fifo.sv @@
module sbld_fifo
  import sbld_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t pop_data_o,
  output logic  empty_o
);

  work_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o     = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ rtl/sbld_back.sv @@
module sbld_back
  import sbld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [OWNER_W-1:0] owner_mask_i,
  input  logic               empty_i,
  input  work_t              pop_data_i,
  output logic               pop_o,
  sbld_smer_if.source        out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIN1,
    S_MIN2,
    S_DEC,
    S_EMIT_OLD,
    S_H1,
    S_H2,
    S_OPEN,
    S_FLUSH
  } state_e;

  state_e state_q;
  work_t  work_q;

  logic [MMER_W-1:0]        grp_val_q [NGRP];
  logic [OFF_W-1:0]         grp_off_q [NGRP];
  logic [MMER_W-1:0]        mcode_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [HASH_W-1:0]        h1_q;
  logic [HASH_W-1:0]        h2_q;

  logic [SMER_W-1:0]        open_smer_q;
  logic [LEN_W-1:0]         open_len_q;
  logic [OWNER_W-1:0]       open_owner_q;
  logic [POSITION_BITS-1:0] prev_pos_q;

  logic                     out_valid_q;
  logic [SMER_W-1:0]        out_smer_q;
  logic [LEN_W-1:0]         out_len_q;
  logic [OWNER_W-1:0]       out_owner_q;
  logic                     out_done_q;
  logic                     out_lir_q;

  logic [MMER_W-1:0]        grp_val_d [NGRP];
  logic [OFF_W-1:0]         grp_off_d [NGRP];
  logic [MMER_W-1:0]        mcode_d;
  logic [OFF_W-1:0]         off_d;
  logic [HASH_W-1:0]        h0;
  logic [HASH_W-1:0]        h1_x;
  logic [HASH_W-1:0]        h2_x;
  logic [HASH_W-1:0]        fin;
  logic                     slot_free;
  logic                     out_load;
  logic                     extend;

  // first stage of the minimum search: least m-mer within each group of offsets
  always_comb begin
    logic [MMER_W-1:0] v;
    int                idx;
    v = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_val_d[g] = '0;
      grp_off_d[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        idx = g * GRP_SIZE + j;
        if (idx < NCAND) begin
          v = work_q.window[2 * (NCAND - 1 - idx) +: MMER_W];
          if (j == 0 || v < grp_val_d[g]) begin
            grp_val_d[g] = v;
            grp_off_d[g] = OFF_W'(idx);
          end
        end
      end
    end
  end

  // second stage: earliest group wins a tie
  always_comb begin
    mcode_d = grp_val_q[0];
    off_d   = grp_off_q[0];
    for (int g = 1; g < NGRP; g++) begin
      if (grp_val_q[g] < mcode_d) begin
        mcode_d = grp_val_q[g];
        off_d   = grp_off_q[g];
      end
    end
  end

  always_comb begin
    h0 = '0;
    for (int i = 0; i < 4; i++) begin
      h0[8*i +: 8] = ascii_of(mcode_q[2 * (MINIMIZER_LEN - 1 - i) +: 2]);
    end
    h1_x = h0 ^ (h0 >> 16);
    h2_x = h1_q ^ (h1_q >> 13);
    fin  = h2_q ^ (h2_q >> 16);
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign out_load  = slot_free && ((state_q == S_EMIT_OLD) || (state_q == S_FLUSH));
  assign extend    = (pos_q == prev_pos_q) && (open_len_q < LEN_W'(SMER_BASES));
  assign pop_o     = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      work_q       <= '0;
      mcode_q      <= '0;
      pos_q        <= '0;
      h1_q         <= '0;
      h2_q         <= '0;
      open_smer_q  <= '0;
      open_len_q   <= '0;
      open_owner_q <= '0;
      prev_pos_q   <= '0;
      out_valid_q  <= 1'b0;
      out_smer_q   <= '0;
      out_len_q    <= '0;
      out_owner_q  <= '0;
      out_done_q   <= 1'b0;
      out_lir_q    <= 1'b0;
      for (int g = 0; g < NGRP; g++) begin
        grp_val_q[g] <= '0;
        grp_off_q[g] <= '0;
      end
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            work_q  <= pop_data_i;
            state_q <= S_MIN1;
          end
        end
        S_MIN1: begin
          for (int g = 0; g < NGRP; g++) begin
            grp_val_q[g] <= grp_val_d[g];
            grp_off_q[g] <= grp_off_d[g];
          end
          state_q <= S_MIN2;
        end
        S_MIN2: begin
          mcode_q <= mcode_d;
          pos_q   <= work_q.pos_base + POSITION_BITS'(off_d);
          state_q <= S_DEC;
        end
        S_DEC: begin
          prev_pos_q <= pos_q;
          if (work_q.kind == KIND_OPEN) begin
            state_q <= S_H1;
          end else if (extend) begin
            open_smer_q[{~open_len_q[4:0], 1'b0} +: 2] <= work_q.base;
            open_len_q <= open_len_q + LEN_W'(1);
            state_q    <= work_q.read_end ? S_FLUSH : S_IDLE;
          end else begin
            state_q <= S_EMIT_OLD;
          end
        end
        S_EMIT_OLD: begin
          if (slot_free) begin
            out_smer_q  <= open_smer_q;
            out_len_q   <= open_len_q;
            out_owner_q <= open_owner_q;
            out_done_q  <= 1'b0;
            out_lir_q   <= !work_q.read_end;
            state_q     <= S_H1;
          end
        end
        S_H1: begin
          h1_q    <= h1_x * HASH_C1;
          state_q <= S_H2;
        end
        S_H2: begin
          h2_q    <= h2_x * HASH_C2;
          state_q <= S_OPEN;
        end
        S_OPEN: begin
          open_smer_q  <= {work_q.window, {(SMER_W - WIN_W){1'b0}}};
          open_len_q   <= LEN_W'(KMER_LEN);
          open_owner_q <= fin[OWNER_W-1:0] & owner_mask_i;
          state_q      <= work_q.read_end ? S_FLUSH : S_IDLE;
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_smer_q  <= open_smer_q;
            out_len_q   <= open_len_q;
            out_owner_q <= open_owner_q;
            out_done_q  <= 1'b1;
            out_lir_q   <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.packed_bases = out_smer_q;
  assign out_o.supermer_len = out_len_q;
  assign out_o.owner_id     = out_owner_q;
  assign out_o.read_done    = out_done_q;
  assign out_o.last_in_run  = out_lir_q;

`ifndef NO_ASSERTIONS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_len_q >= LEN_W'(KMER_LEN)) && (out_len_q <= LEN_W'(SMER_BASES)))
    else $error("supermer length out of range");
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_lir_q) else $error("read end result not last of item");
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_smer_q << {out_len_q, 1'b0}) == '0))
    else $error("bits past last base not zero");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_MIN1)) else $error("popped item not taken");
`endif

endmodule

@@ rtl/supermer_builder_core.sv @@
// Supermer builder: DNA bases in, minimizer-partitioned supermers out.
// in_i carries one base per item (base_code, read_end); an item is taken on
// valid && ready. out_o carries one supermer per item: bases packed two bits
// each from bit 63 down, its length, owner and read_done; last_in_run marks
// the final result caused by one base. cfg_we_i/cfg_wdata_i load owner_mask.
// Throughput: the front takes a base every cycle while the 4-entry work
// queue has room. The back handles one queued base at a time: from S_IDLE
// a base that extends the open supermer passes S_MIN1, S_MIN2 and S_DEC;
// one that moves the minimizer and closes a supermer also passes
// S_EMIT_OLD, S_H1, S_H2 and S_OPEN, and a read end adds S_FLUSH. The
// minimum search runs in S_MIN1 and S_MIN2, the two-multiply owner hash in
// S_H1 and S_H2. Bases before the first full k-mer never enter the queue.
// A stalled receiver holds the output register; the back then waits, the
// queue fills and in_i.ready drops. Reset empties the queue, clears the read
// state and owner_mask; the block accepts input as soon as reset is released.
module supermer_builder_core
  import sbld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sbld_base_if.sink          in_i,
  sbld_smer_if.source        out_o,
  input  logic               cfg_we_i,
  input  logic [OWNER_W-1:0] cfg_wdata_i
);

  logic [OWNER_W-1:0] owner_mask_q;
  logic               push;
  work_t              push_data;
  logic               full;
  logic               pop;
  work_t              pop_data;
  logic               empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_mask_q <= '0;
    end else if (cfg_we_i) begin
      owner_mask_q <= cfg_wdata_i;
    end
  end

  sbld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sbld_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  sbld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .owner_mask_i (owner_mask_q),
    .empty_i      (empty),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
